[rtl/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the barometric pressure compensation unit.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RAW_W     = 24;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 32;

    // temperature thresholds, hundredths of a degree
    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -19'sd1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS       = 3'd0,
        CFG_OFF        = 3'd1,
        CFG_SENS_TC    = 3'd2,
        CFG_OFF_TC     = 3'd3,
        CFG_REF_TEMP   = 3'd4,
        CFG_TEMP_SLOPE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] off;
        logic [COEF_W-1:0] sens_tc;
        logic [COEF_W-1:0] off_tc;
        logic [COEF_W-1:0] ref_temp;
        logic [COEF_W-1:0] temp_slope;
    } t_coef;

endpackage

[rtl/barometric_pressure_compensation_unit.sv]
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_unit
// Second-order compensated temperature and pressure from raw readings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_raw_pressure and
//   i_raw_temperature. A request is taken at a clock edge with valid high
//   and stall low.
//   Output channel: o_out_valid / i_out_stall with the temperature, the
//   pressure and two flags. A result is taken when valid is high and stall low.
//   Calibration words are written through i_cfg_we / i_cfg_idx / i_cfg_wdata
//   while no request is in flight.
//   Stages: nine registers; o_out_valid is the valid bit of the last one.
//   Throughput: one request per cycle unless the output stalls, set by the
//   pipeline of three multiplier rows (dT terms, squares, final split product).
//   Stall: each stage holds only while it is full and the next one is held,
//   so empty slots fill up; o_in_stall rises only when all nine are full.
//   Reset: synchronous, active low; empties the pipeline and zeroes all
//   six calibration words.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bpc_pkg::COEF_W-1:0]        i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bpc_pkg::RAW_W-1:0]         i_raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]         i_raw_temperature,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [bpc_pkg::TEMP_W-1:0] o_temperature_centi,
    output logic signed [bpc_pkg::PRES_W-1:0] o_pressure_pa,
    output logic                              o_low_temp_applied,
    output logic                              o_sample_valid
);

    localparam int NSTG = 9;

    bpc_pkg::t_coef coef;

    bpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_coef      (coef)
    );

    // ---------------- stage flow control ----------------
    logic [NSTG:1] r_v;
    logic [NSTG:1] en;

    always_comb begin
        en[NSTG] = !r_v[NSTG] || !i_out_stall;
        for (int k = NSTG - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !en[1];
    assign o_out_valid = r_v[NSTG];

    // ---------------- stage 1: dT ----------------
    logic        [23:0] r1_d1;
    logic signed [24:0] r1_dt;
    logic               r1_zero;
    logic signed [24:0] n1_dt;

    assign n1_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, coef.ref_temp, 8'h00});

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_d1   <= i_raw_pressure;
            r1_dt   <= n1_dt;
            r1_zero <= (i_raw_pressure == '0) || (i_raw_temperature == '0);
        end
    end

    // ---------------- stage 2: dT products ----------------
    logic        [23:0] r2_d1;
    logic               r2_zero;
    logic signed [41:0] r2_pt, r2_po, r2_ps;
    logic signed [41:0] n2_pt, n2_po, n2_ps;

    assign n2_pt = r1_dt * $signed({1'b0, coef.temp_slope});
    assign n2_po = r1_dt * $signed({1'b0, coef.off_tc});
    assign n2_ps = r1_dt * $signed({1'b0, coef.sens_tc});

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_d1   <= r1_d1;
            r2_zero <= r1_zero;
            r2_pt   <= n2_pt;
            r2_po   <= n2_po;
            r2_ps   <= n2_ps;
        end
    end

    // ---------------- stage 3: first-order terms ----------------
    logic        [23:0] r3_d1;
    logic               r3_zero;
    logic signed [18:0] r3_temp;
    logic signed [39:0] r3_off1, r3_sens1;
    logic signed [18:0] n3_temp;
    logic signed [39:0] n3_off1, n3_sens1;

    // part-selects of the products are the floor shifts
    assign n3_temp  = $signed(r2_pt[41:23]) + bpc_pkg::TEMP_REF;
    assign n3_off1  = $signed({8'h00, coef.off, 16'h0000})
                    + 40'($signed(r2_po[41:7]));
    assign n3_sens1 = $signed({9'd0, coef.sens, 15'd0})
                    + 40'($signed(r2_ps[41:8]));

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_d1    <= r2_d1;
            r3_zero  <= r2_zero;
            r3_temp  <= n3_temp;
            r3_off1  <= n3_off1;
            r3_sens1 <= n3_sens1;
        end
    end

    // ---------------- stage 4: squares ----------------
    logic        [23:0] r4_d1;
    logic               r4_zero;
    logic signed [18:0] r4_temp;
    logic signed [39:0] r4_off1, r4_sens1;
    logic               r4_low, r4_vlow;
    logic        [35:0] r4_sq, r4_sq2;
    logic signed [19:0] n4_a, n4_b;
    logic signed [39:0] n4_sq, n4_sq2;

    assign n4_a   = 20'(r3_temp) - 20'(bpc_pkg::TEMP_REF);
    assign n4_b   = 20'(r3_temp) - 20'(bpc_pkg::TEMP_VLOW);
    assign n4_sq  = n4_a * n4_a;
    assign n4_sq2 = n4_b * n4_b;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_d1    <= r3_d1;
            r4_zero  <= r3_zero;
            r4_temp  <= r3_temp;
            r4_off1  <= r3_off1;
            r4_sens1 <= r3_sens1;
            r4_low   <= r3_temp < bpc_pkg::TEMP_REF;
            r4_vlow  <= r3_temp < bpc_pkg::TEMP_VLOW;
            r4_sq    <= n4_sq[35:0];
            r4_sq2   <= n4_sq2[35:0];
        end
    end

    // ---------------- stage 5: second-order corrections ----------------
    logic        [23:0] r5_d1;
    logic               r5_zero;
    logic signed [18:0] r5_temp;
    logic signed [39:0] r5_off1, r5_sens1;
    logic               r5_low;
    logic        [39:0] r5_off2, r5_sens2;
    logic        [38:0] n5_five, n5_sev;
    logic        [39:0] n5_ele;
    logic        [39:0] n5_off2, n5_sens2;

    // constant multiples by shift and add
    assign n5_five = {3'b000, r4_sq} + {1'b0, r4_sq, 2'b00};
    assign n5_sev  = {r4_sq2, 3'b000} - {3'b000, r4_sq2};
    assign n5_ele  = {1'b0, r4_sq2, 3'b000} + {3'b000, r4_sq2, 1'b0} + {4'h0, r4_sq2};

    always_comb begin
        n5_off2  = {2'b00, n5_five[38:1]};
        n5_sens2 = {3'b000, n5_five[38:2]};
        if (r4_vlow) begin
            n5_off2  = n5_off2 + {1'b0, n5_sev};
            n5_sens2 = n5_sens2 + {1'b0, n5_ele[39:1]};
        end
        if (!r4_low) begin
            n5_off2  = '0;
            n5_sens2 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_d1    <= r4_d1;
            r5_zero  <= r4_zero;
            r5_temp  <= r4_temp;
            r5_off1  <= r4_off1;
            r5_sens1 <= r4_sens1;
            r5_low   <= r4_low;
            r5_off2  <= n5_off2;
            r5_sens2 <= n5_sens2;
        end
    end

    // ---------------- stage 6: corrected OFF / SENS ----------------
    logic        [23:0] r6_d1;
    logic               r6_zero;
    logic signed [18:0] r6_temp;
    logic               r6_low;
    logic signed [39:0] r6_off, r6_sens;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_d1   <= r5_d1;
            r6_zero <= r5_zero;
            r6_temp <= r5_temp;
            r6_low  <= r5_low;
            r6_off  <= r5_off1 - $signed(r5_off2);
            r6_sens <= r5_sens1 - $signed(r5_sens2);
        end
    end

    // ---------------- stage 7: D1 * SENS partial products ----------------
    logic               r7_zero;
    logic signed [18:0] r7_temp;
    logic               r7_low;
    logic signed [39:0] r7_off;
    logic        [43:0] r7_pl;
    logic signed [44:0] r7_ph;
    logic        [43:0] n7_pl;
    logic signed [44:0] n7_ph;

    assign n7_pl = r6_d1 * r6_sens[19:0];
    assign n7_ph = $signed({1'b0, r6_d1}) * $signed(r6_sens[39:20]);

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_zero <= r6_zero;
            r7_temp <= r6_temp;
            r7_low  <= r6_low;
            r7_off  <= r6_off;
            r7_pl   <= n7_pl;
            r7_ph   <= n7_ph;
        end
    end

    // ---------------- stage 8: product sum ----------------
    logic               r8_zero;
    logic signed [18:0] r8_temp;
    logic               r8_low;
    logic signed [39:0] r8_off;
    logic signed [64:0] r8_prod;

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r8_zero <= r7_zero;
            r8_temp <= r7_temp;
            r8_low  <= r7_low;
            r8_off  <= r7_off;
            r8_prod <= $signed({r7_ph, 20'h00000}) + $signed({21'd0, r7_pl});
        end
    end

    // ---------------- stage 9: pressure and output register ----------------
    logic signed [47:0] n9_diff;

    assign n9_diff = 48'($signed(r8_prod[64:21])) - 48'(r8_off);

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            o_sample_valid <= !r8_zero;
            if (r8_zero) begin
                o_temperature_centi <= '0;
                o_pressure_pa       <= '0;
                o_low_temp_applied  <= 1'b0;
            end else begin
                o_temperature_centi <= r8_temp;
                o_pressure_pa       <= $signed(n9_diff[46:15]);
                o_low_temp_applied  <= r8_low;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // invalid samples carry all-zero results
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_sample_valid) |->
            (o_pressure_pa == '0 && o_temperature_centi == '0 && !o_low_temp_applied))
        else $error("invalid sample with nonzero result");

    // low-temperature flag tracks the delivered temperature
    a_low_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sample_valid) |->
            (o_low_temp_applied == (o_temperature_centi < bpc_pkg::TEMP_REF)))
        else $error("low temperature flag disagrees with temperature");

    // input is held off only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_v && i_out_stall))
        else $error("input stalled with a free pipeline slot");
`endif

endmodule

[rtl/bpc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Calibration coefficient register file; writes to unknown indexes drop.
// ----------------------------------------------------------------------------
module bpc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpc_pkg::COEF_W-1:0]     i_cfg_wdata,
    output bpc_pkg::t_coef                 o_coef
);

    bpc_pkg::t_coef r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we) begin
            case (bpc_pkg::t_cfg_idx'(i_cfg_idx))
                bpc_pkg::CFG_SENS:       r_coef.sens       <= i_cfg_wdata;
                bpc_pkg::CFG_OFF:        r_coef.off        <= i_cfg_wdata;
                bpc_pkg::CFG_SENS_TC:    r_coef.sens_tc    <= i_cfg_wdata;
                bpc_pkg::CFG_OFF_TC:     r_coef.off_tc     <= i_cfg_wdata;
                bpc_pkg::CFG_REF_TEMP:   r_coef.ref_temp   <= i_cfg_wdata;
                bpc_pkg::CFG_TEMP_SLOPE: r_coef.temp_slope <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_coef = r_coef;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the barometric pressure compensation unit. A queue
// of raw pressure/temperature pairs feeds a bursty driver; a monitor checks
// each result against an in-bench compensation calculation, in order, while
// the output side stalls on its own pattern. Calibration words change
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int COEF_W    = bpc_pkg::COEF_W;
    localparam int CFG_IDX_W = bpc_pkg::CFG_IDX_W;
    localparam int RAW_W     = bpc_pkg::RAW_W;
    localparam int TEMP_W    = bpc_pkg::TEMP_W;
    localparam int PRES_W    = bpc_pkg::PRES_W;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_CYCLES     = 80;
    localparam int TAIL_CYCLES     = 20;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int HOLD_PHASE      = 3;
    localparam int PAUSE_PHASE     = 6;
    localparam int MAX_REPORTS     = 10;

    // register indexes past the last calibration word; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE7 = 3'd7;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALT
    } t_stall_mode;

    typedef struct packed {
        logic [RAW_W-1:0] pres;
        logic [RAW_W-1:0] temp;
    } t_raw_pair;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [PRES_W-1:0] pres;
        logic                     low;
        logic                     valid;
    } t_comp_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [COEF_W-1:0]        i_cfg_wdata;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [RAW_W-1:0]         i_raw_pressure;
    logic [RAW_W-1:0]         i_raw_temperature;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [TEMP_W-1:0] o_temperature_centi;
    logic signed [PRES_W-1:0] o_pressure_pa;
    logic                     o_low_temp_applied;
    logic                     o_sample_valid;

    barometric_pressure_compensation_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_raw_pressure      (i_raw_pressure),
        .i_raw_temperature   (i_raw_temperature),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_pa       (o_pressure_pa),
        .o_low_temp_applied  (o_low_temp_applied),
        .o_sample_valid      (o_sample_valid)
    );

    t_raw_pair       pending_q[$];
    t_comp_result    expected_q[$];
    bpc_pkg::t_coef  cal;

    bit          in_taken;
    bit          offering;
    int          burst_left;
    int          gap_left;
    bit          hold_req;
    int          hold_cnt;
    t_stall_mode stall_mode;
    int          mode_left;
    int          idle_cycles;

    int n_accepted;
    int n_results;
    int n_fail;
    int n_settings;
    int n_invalid;
    int n_low;
    int n_vlow;

    // compensated temperature and pressure for one raw pair
    function automatic t_comp_result compensate(input logic [RAW_W-1:0] d1_raw,
                                                input logic [RAW_W-1:0] d2_raw,
                                                input bpc_pkg::t_coef c);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, tc, off, sens, a, sq, off2, sens2, b, sq2, p;
        t_comp_result r;
        r = '0;
        if (d1_raw == '0 || d2_raw == '0) begin
            return r;
        end
        d1 = d1_raw;
        d2 = d2_raw;
        c1 = c.sens;
        c2 = c.off;
        c3 = c.sens_tc;
        c4 = c.off_tc;
        c5 = c.ref_temp;
        c6 = c.temp_slope;
        dt   = d2 - c5 * 256;
        tc   = 2000 + ((dt * c6) >>> 23);
        off  = c2 * 65536 + ((c4 * dt) >>> 7);
        sens = c1 * 32768 + ((c3 * dt) >>> 8);
        if (tc < bpc_pkg::TEMP_REF) begin
            a     = tc - 2000;
            sq    = a * a;
            off2  = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            r.low = 1'b1;
            if (tc < bpc_pkg::TEMP_VLOW) begin
                b     = tc + 1500;
                sq2   = b * b;
                off2  = off2 + 7 * sq2;
                sens2 = sens2 + ((11 * sq2) >>> 1);
            end
            off  = off - off2;
            sens = sens - sens2;
        end
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        r.temp  = tc[TEMP_W-1:0];
        r.pres  = p[PRES_W-1:0];
        r.valid = 1'b1;
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0) return '0;
        if (k == 1) return '1;
        return COEF_W'($urandom);
    endfunction

    function automatic t_raw_pair rand_pair(input bpc_pkg::t_coef c);
        t_raw_pair   r;
        int unsigned k;
        int unsigned sh;
        longint      v;
        k = $urandom_range(0, 99);
        if (k < 4)       r.pres = '0;
        else if (k < 8)  r.pres = '1;
        else if (k < 10) r.pres = 24'd1;
        else             r.pres = RAW_W'($urandom);
        k = $urandom_range(0, 99);
        if (k < 4)       r.temp = '0;
        else if (k < 7)  r.temp = '1;
        else if (k < 9)  r.temp = 24'd1;
        else if (k < 45) begin
            // close to the reference point, where the low-temperature branch toggles
            sh = $urandom_range(0, 20);
            v  = $urandom_range(0, 1 << sh);
            v  = $urandom_range(0, 1) ? -v : v;
            v  = longint'(c.ref_temp) * 256 + v;
            if (v < 1) v = 1;
            if (v > 24'hFFFFFF) v = 24'hFFFFFF;
            r.temp = v[RAW_W-1:0];
        end else begin
            r.temp = RAW_W'($urandom);
        end
        return r;
    endfunction

    task automatic push_pair(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
        t_raw_pair r;
        r.pres = p;
        r.temp = t;
        pending_q.push_back(r);
    endtask

    task automatic fill_random(input int count);
        repeat (count) pending_q.push_back(rand_pair(cal));
    endtask

    // sender and pipeline both empty
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (!(pending_q.size() == 0 && !i_in_valid && expected_q.size() == 0));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            bpc_pkg::CFG_SENS:       cal.sens       = val;
            bpc_pkg::CFG_OFF:        cal.off        = val;
            bpc_pkg::CFG_SENS_TC:    cal.sens_tc    = val;
            bpc_pkg::CFG_OFF_TC:     cal.off_tc     = val;
            bpc_pkg::CFG_REF_TEMP:   cal.ref_temp   = val;
            bpc_pkg::CFG_TEMP_SLOPE: cal.temp_slope = val;
            default: ;
        endcase
    endtask

    task automatic load_coefs(input bpc_pkg::t_coef c);
        wait_idle();
        write_reg(bpc_pkg::CFG_SENS, c.sens);
        write_reg(bpc_pkg::CFG_OFF, c.off);
        write_reg(bpc_pkg::CFG_SENS_TC, c.sens_tc);
        write_reg(bpc_pkg::CFG_OFF_TC, c.off_tc);
        write_reg(bpc_pkg::CFG_REF_TEMP, c.ref_temp);
        write_reg(bpc_pkg::CFG_TEMP_SLOPE, c.temp_slope);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request driver: bursts of random length, random gaps, junk payload when idle
    always @(negedge i_clk) begin
        t_raw_pair nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
            in_taken = 1'b0;
            burst_left = $urandom_range(1, 32);
            gap_left = 0;
        end else begin
            if (in_taken) begin
                in_taken = 1'b0;
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left == 0 && pending_q.size() > 0) begin
                    nxt = pending_q.pop_front();
                    i_raw_pressure    <= nxt.pres;
                    i_raw_temperature <= nxt.temp;
                    offering = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    if (gap_left > 0) gap_left--;
                    i_raw_pressure    <= RAW_W'($urandom);
                    i_raw_temperature <= RAW_W'($urandom);
                end
            end
            i_in_valid <= offering;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cnt = 0;
            mode_left = 0;
        end else if (hold_req) begin
            // long hold-off so the pipeline fills and stalls its input
            if (hold_cnt < HOLD_CYCLES) begin
                hold_cnt++;
                i_out_stall <= 1'b1;
            end else begin
                hold_cnt = 0;
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                STALL_ALT:   i_out_stall <= ~i_out_stall;
                default:     i_out_stall <= 1'b0;
            endcase
        end
    end

    // monitor: predict on accepted requests, check accepted results, watchdog
    always @(posedge i_clk) begin
        t_comp_result exp_in;
        t_comp_result exp_out;
        t_comp_result got;
        bit           progress;
        if (i_rst_n) begin
            progress = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                exp_in = compensate(i_raw_pressure, i_raw_temperature, cal);
                expected_q.push_back(exp_in);
                in_taken = 1'b1;
                progress = 1'b1;
                n_accepted++;
                if (!exp_in.valid) n_invalid++;
                if (exp_in.low) n_low++;
                if (exp_in.valid && exp_in.temp < bpc_pkg::TEMP_VLOW) n_vlow++;
            end
            if (o_out_valid && !i_out_stall) begin
                progress = 1'b1;
                n_results++;
                got.temp  = o_temperature_centi;
                got.pres  = o_pressure_pa;
                got.low   = o_low_temp_applied;
                got.valid = o_sample_valid;
                if (expected_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("ERROR: result with nothing pending: temp %0d pres %0d",
                                 got.temp, got.pres);
                end else begin
                    exp_out = expected_q.pop_front();
                    if (got.temp !== exp_out.temp || got.pres !== exp_out.pres ||
                        got.low !== exp_out.low || got.valid !== exp_out.valid) begin
                        n_fail++;
                        if (n_fail <= MAX_REPORTS) begin
                            $display("ERROR: result %0d: exp temp %0d pres %0d low %0b valid %0b",
                                     n_results, exp_out.temp, exp_out.pres, exp_out.low,
                                     exp_out.valid);
                            $display("       got temp %0d pres %0d low %0b valid %0b",
                                     got.temp, got.pres, got.low, got.valid);
                        end
                    end
                end
            end
            if (progress) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("ERROR: no handshake for %0d cycles", idle_cycles);
                    $display("barometric_pressure_compensation_unit verification failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        bpc_pkg::t_coef c;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_wdata       = '0;
        i_in_valid        = 1'b0;
        i_raw_pressure    = '0;
        i_raw_temperature = '0;
        i_out_stall       = 1'b0;
        cal               = '0;
        hold_req          = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // calibration words still at their reset value
        push_pair(24'd9085466, 24'd8569150);
        push_pair(24'hFFFFFF, 24'hFFFFFF);

        c.sens       = 16'd40127;
        c.off        = 16'd36924;
        c.sens_tc    = 16'd23317;
        c.off_tc     = 16'd23282;
        c.ref_temp   = 16'd33464;
        c.temp_slope = 16'd28312;
        load_coefs(c);
        push_pair(24'd9085466, 24'd8569150);
        push_pair(24'd0, 24'd8569150);
        push_pair(24'd9085466, 24'd0);
        push_pair(24'd0, 24'd0);
        push_pair(24'hFFFFFF, 24'hFFFFFF);
        push_pair(24'd1, 24'd1);
        push_pair(24'hFFFFFF, 24'd1);
        push_pair(24'd1, 24'hFFFFFF);

        // indexes past the last word must leave the calibration alone
        wait_idle();
        write_reg(CFG_IDX_SPARE6, 16'hFFFF);
        write_reg(CFG_IDX_SPARE7, 16'h0000);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        push_pair(24'd9085466, 24'd8569150);

        // slope and reference chosen so that TEMP = 2000 + (dT >>> 8)
        c.ref_temp   = 16'd32768;
        c.temp_slope = 16'd32768;
        load_coefs(c);
        push_pair(24'd9085466, 24'd8388608);   // exactly 20.00 C
        push_pair(24'hFFFFFF, 24'd8388352);    // 19.99 C, first low step
        push_pair(24'd9085466, 24'd8388864);   // 20.01 C
        push_pair(24'd1, 24'd7492608);         // exactly -15.00 C
        push_pair(24'd9085466, 24'd7492352);   // -15.01 C, stronger term kicks in

        c = '1;
        load_coefs(c);
        push_pair(24'hFFFFFF, 24'hFFFFFF);
        push_pair(24'hFFFFFF, 24'd1);
        push_pair(24'd1, 24'hFFFFFF);
        push_pair(24'h800000, 24'h800000);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            c.sens       = rand_coef();
            c.off        = rand_coef();
            c.sens_tc    = rand_coef();
            c.off_tc     = rand_coef();
            c.ref_temp   = rand_coef();
            c.temp_slope = rand_coef();
            load_coefs(c);
            if (ph == HOLD_PHASE) begin
                fill_random(ITEMS_PER_PHASE);
                hold_req = 1'b1;
                wait (!hold_req);
            end else if (ph == PAUSE_PHASE) begin
                fill_random(ITEMS_PER_PHASE / 2);
                wait_idle();
                fill_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
            end else begin
                fill_random(ITEMS_PER_PHASE);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            n_fail++;
            $display("ERROR: %0d results never arrived", expected_q.size());
        end
        $display("covered %0d requests and %0d results over %0d calibration settings",
                 n_accepted, n_results, n_settings);
        $display("  %0d invalid samples, %0d below 20.00 C, %0d below -15.00 C, %0d mismatches",
                 n_invalid, n_low, n_vlow, n_fail);
        if (n_fail == 0) begin
            $display("barometric_pressure_compensation_unit verification clean");
        end else begin
            $display("barometric_pressure_compensation_unit verification failed");
        end
        $finish;
    end

endmodule

[barometric_pressure_compensation_unit.f]
rtl/bpc_pkg.sv
rtl/bpc_cfg_regs.sv
rtl/barometric_pressure_compensation_unit.sv
verif/tb_top.sv
